// File: hw/rtl/spm_pkg.sv
// Shared types, widths and saturation helpers for the sparse polynomial multiplier.
// Used by spm_mul and sparse_polynomial_multiply; depends on nothing else.
package spm_pkg;

    localparam int COEF_W        = 32;
    localparam int EXP_W         = 8;
    localparam int REXP_W        = 9;
    localparam int TERMS_DEFAULT = 8;
    localparam int EXPMAX_DEFAULT = 255;

    typedef enum logic [1:0] {
        KIND_LOAD_A = 2'd0,
        KIND_LOAD_B = 2'd1,
        KIND_GO     = 2'd2
    } kind_t;

    // Clamp a wide signed value to the 32-bit signed range.
    function automatic logic signed [COEF_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] max_v;
        logic signed [63:0] min_v;
        max_v = 64'sh0000_0000_7FFF_FFFF;
        min_v = -64'sh0000_0000_8000_0000;
        if (v > max_v) begin
            return {1'b0, {(COEF_W-1){1'b1}}};
        end else if (v < min_v) begin
            return {1'b1, {(COEF_W-1){1'b0}}};
        end else begin
            return v[COEF_W-1:0];
        end
    endfunction

endpackage

// File: hw/rtl/spm_acc_mem.sv
// Accumulator store: one write port and one read port with registered read data.
// Depends on nothing else; instantiated by sparse_polynomial_multiply.
module spm_acc_mem #(
    parameter int DEPTH = 511,
    parameter int AW    = 9
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [31:0]       rd_data,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [31:0]       wr_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    // A read and a write of the same entry in one cycle return the old value.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/spm_mul.sv
// Two-stage Q16.16 product unit: a registered 32x32 multiply, then shift and saturate.
// Depends on spm_pkg; instantiated by sparse_polynomial_multiply.
module spm_mul (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    input  logic signed [spm_pkg::COEF_W-1:0]    in_a,
    input  logic signed [spm_pkg::COEF_W-1:0]    in_b,
    input  logic [spm_pkg::REXP_W-1:0]           in_exp,
    output logic                                 out_valid,
    output logic signed [spm_pkg::COEF_W-1:0]    out_coef,
    output logic [spm_pkg::REXP_W-1:0]           out_exp,
    output logic                                 busy
);
    import spm_pkg::*;

    logic                      v1_reg;
    logic signed [63:0]        prod_reg;
    logic [REXP_W-1:0]         e1_reg;
    logic                      v2_reg;
    logic signed [COEF_W-1:0]  c2_reg;
    logic [REXP_W-1:0]         e2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
        prod_reg <= 64'(in_a) * 64'(in_b);
        e1_reg   <= in_exp;
        // Arithmetic shift rounds toward minus infinity.
        c2_reg   <= sat32(prod_reg >>> 16);
        e2_reg   <= e1_reg;
    end

    assign out_valid = v2_reg;
    assign out_coef  = c2_reg;
    assign out_exp   = e2_reg;
    assign busy      = v1_reg | v2_reg;

endmodule

// File: hw/rtl/sparse_polynomial_multiply.sv
// Sparse polynomial multiplier: top level with operand stores, sequencer and output stage.
// Depends on spm_pkg, spm_mul and spm_acc_mem.
//
// Usage. Requests arrive on the s_ channel; s_tuser carries the kind. Kind 0 loads an
// operand A term and kind 1 an operand B term (coefficient Q16.16, exponent); terms
// beyond TERMS are dropped and flagged. Kind 2 multiplies every A term with every B term,
// accumulates with saturation into the accumulator memory by summed exponent, then scans
// the memory from the top exponent down and sends each nonzero entry on the m_ channel,
// clearing it on the way. m_tlast marks the final term; an all-zero product gives one
// item with the zero flag set. Unused kinds are ignored.
// Timing. A multiply request runs one product per cycle through the multiplier, then
// one accumulator entry per cycle over the single memory read port while the receiver
// keeps up. The first result leaves once the scan meets the second nonzero entry or
// ends; the last leaves at the end of the scan. s_tready is low during the multiply
// and the scan. When the receiver stalls, one result waits in the output register
// and the scan pauses until it is taken.
// Reset. After aresetn the accumulator is cleared in one pass over its 2*EXP_MAX+1
// entries with s_tready low; operand counts and the drop flag start at zero.
module sparse_polynomial_multiply #(
    parameter int TERMS   = spm_pkg::TERMS_DEFAULT,
    parameter int EXP_MAX = spm_pkg::EXPMAX_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] coefficient, [39:32] exponent
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] result_coefficient, [40:32] result_exponent
    output logic [1:0]  m_tuser,   // [0] zero_result, [1] overflow
    output logic        m_tlast
);
    import spm_pkg::*;

    localparam int ACC_DEPTH = 2 * EXP_MAX + 1;
    localparam int ACC_AW    = $clog2(ACC_DEPTH);
    localparam int CNT_W     = $clog2(TERMS + 1);
    localparam int IDX_W     = (TERMS > 1) ? $clog2(TERMS) : 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_SCAN
    } state_t;

    state_t state_reg;

    // Operand stores.
    logic signed [COEF_W-1:0] a_coef_reg [TERMS];
    logic [EXP_W-1:0]         a_exp_reg  [TERMS];
    logic signed [COEF_W-1:0] b_coef_reg [TERMS];
    logic [EXP_W-1:0]         b_exp_reg  [TERMS];
    logic [CNT_W-1:0]         a_count_reg;
    logic [CNT_W-1:0]         b_count_reg;
    logic                     dropped_reg;

    // Product walk.
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] j_reg;
    logic             i_last;
    logic             j_last;
    logic             iss_v;
    logic [REXP_W-1:0] iss_exp;

    logic                     p_valid;
    logic signed [COEF_W-1:0] p_coef;
    logic [REXP_W-1:0]        p_exp;
    logic                     mul_busy;

    logic                     v3_reg;
    logic [ACC_AW-1:0]        e3_reg;
    logic signed [COEF_W-1:0] c3_reg;
    logic                     fwd_v_reg;
    logic [ACC_AW-1:0]        fwd_a_reg;
    logic signed [COEF_W-1:0] fwd_d_reg;
    logic signed [COEF_W-1:0] acc_old;
    logic signed [COEF_W-1:0] acc_sum;

    // Scan and clear.
    logic [ACC_AW-1:0]        sc_addr_reg;
    logic                     sc_more_reg;
    logic                     ev_v_reg;
    logic [ACC_AW-1:0]        ev_addr_reg;
    logic                     pend_v_reg;
    logic signed [COEF_W-1:0] pend_coef_reg;
    logic [ACC_AW-1:0]        pend_addr_reg;
    logic                     ev_nz;
    logic                     out_free;
    logic                     stall;
    logic                     scan_issue;
    logic                     scan_end;
    logic                     push_mid;
    logic                     push_end;

    // Accumulator memory port.
    logic              mem_re;
    logic [ACC_AW-1:0] mem_ra;
    logic [31:0]       mem_rd;
    logic              mem_we;
    logic [ACC_AW-1:0] mem_wa;
    logic [31:0]       mem_wd;

    // Output stage.
    logic                     m_valid_reg;
    logic signed [COEF_W-1:0] m_coef_reg;
    logic [REXP_W-1:0]        m_exp_reg;
    logic                     m_last_reg;
    logic                     m_zero_reg;
    logic                     m_ovf_reg;

    logic                     s_fire;
    kind_t                    s_kind;
    logic signed [COEF_W-1:0] s_coef;
    logic [EXP_W-1:0]         s_exp_sat;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign s_kind   = kind_t'(s_tuser);
    assign s_coef   = s_tdata[31:0];
    assign s_exp_sat = (32'(s_tdata[39:32]) > EXP_MAX) ? EXP_W'(EXP_MAX) : s_tdata[39:32];

    // Operand stores hold no reset; only entries below the counts are read.
    always_ff @(posedge aclk) begin
        if (s_fire && s_kind == KIND_LOAD_A && a_count_reg != CNT_W'(TERMS)) begin
            a_coef_reg[a_count_reg[IDX_W-1:0]] <= s_coef;
            a_exp_reg[a_count_reg[IDX_W-1:0]]  <= s_exp_sat;
        end
        if (s_fire && s_kind == KIND_LOAD_B && b_count_reg != CNT_W'(TERMS)) begin
            b_coef_reg[b_count_reg[IDX_W-1:0]] <= s_coef;
            b_exp_reg[b_count_reg[IDX_W-1:0]]  <= s_exp_sat;
        end
    end

    assign i_last  = (CNT_W'(i_reg) == a_count_reg - CNT_W'(1));
    assign j_last  = (CNT_W'(j_reg) == b_count_reg - CNT_W'(1));
    assign iss_v   = (state_reg == ST_MUL);
    assign iss_exp = REXP_W'(a_exp_reg[i_reg]) + REXP_W'(b_exp_reg[j_reg]);

    spm_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (iss_v),
        .in_a      (a_coef_reg[i_reg]),
        .in_b      (b_coef_reg[j_reg]),
        .in_exp    (iss_exp),
        .out_valid (p_valid),
        .out_coef  (p_coef),
        .out_exp   (p_exp),
        .busy      (mul_busy)
    );

    // The entry written last cycle is not yet visible in the read data; take it from
    // the forwarding register instead.
    assign acc_old = (fwd_v_reg && fwd_a_reg == e3_reg) ? fwd_d_reg : $signed(mem_rd);
    assign acc_sum = sat32({{32{acc_old[COEF_W-1]}}, acc_old}
                         + {{32{c3_reg[COEF_W-1]}}, c3_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg    <= 1'b0;
            fwd_v_reg <= 1'b0;
        end else begin
            v3_reg    <= p_valid;
            fwd_v_reg <= v3_reg;
        end
        e3_reg    <= ACC_AW'(p_exp);
        c3_reg    <= p_coef;
        fwd_a_reg <= e3_reg;
        fwd_d_reg <= acc_sum;
    end

    assign ev_nz      = ev_v_reg && (mem_rd != '0);
    assign out_free   = !m_valid_reg || m_tready;
    assign stall      = ev_nz && pend_v_reg && !out_free;
    assign scan_issue = (state_reg == ST_SCAN) && sc_more_reg && !stall;
    assign scan_end   = (state_reg == ST_SCAN) && !sc_more_reg && !ev_v_reg;
    assign push_mid   = (state_reg == ST_SCAN) && ev_nz && pend_v_reg && out_free;
    assign push_end   = scan_end && out_free;

    always_comb begin
        mem_re = 1'b0;
        mem_ra = sc_addr_reg;
        mem_we = 1'b0;
        mem_wa = sc_addr_reg;
        mem_wd = '0;
        case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_MUL, ST_DRAIN: begin
                mem_re = 1'b1;
                mem_ra = ACC_AW'(p_exp);
                mem_we = v3_reg;
                mem_wa = e3_reg;
                mem_wd = acc_sum;
            end
            ST_SCAN: begin
                // Each scanned entry is read and cleared in the same cycle.
                mem_re = scan_issue;
                mem_we = scan_issue;
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    spm_acc_mem #(
        .DEPTH (ACC_DEPTH),
        .AW    (ACC_AW)
    ) u_acc (
        .aclk    (aclk),
        .rd_en   (mem_re),
        .rd_addr (mem_ra),
        .rd_data (mem_rd),
        .wr_en   (mem_we),
        .wr_addr (mem_wa),
        .wr_data (mem_wd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            sc_addr_reg <= ACC_AW'(ACC_DEPTH - 1);
            sc_more_reg <= 1'b0;
            ev_v_reg    <= 1'b0;
            pend_v_reg  <= 1'b0;
            a_count_reg <= '0;
            b_count_reg <= '0;
            dropped_reg <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (push_mid || push_end) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR: begin
                    if (sc_addr_reg == '0) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        sc_addr_reg <= sc_addr_reg - ACC_AW'(1);
                    end
                end
                ST_IDLE: begin
                    if (s_fire) begin
                        case (s_kind)
                            KIND_LOAD_A: begin
                                if (a_count_reg == CNT_W'(TERMS)) begin
                                    dropped_reg <= 1'b1;
                                end else begin
                                    a_count_reg <= a_count_reg + CNT_W'(1);
                                end
                            end
                            KIND_LOAD_B: begin
                                if (b_count_reg == CNT_W'(TERMS)) begin
                                    dropped_reg <= 1'b1;
                                end else begin
                                    b_count_reg <= b_count_reg + CNT_W'(1);
                                end
                            end
                            KIND_GO: begin
                                i_reg <= '0;
                                j_reg <= '0;
                                if (a_count_reg == '0 || b_count_reg == '0) begin
                                    state_reg <= ST_DRAIN;
                                end else begin
                                    state_reg <= ST_MUL;
                                end
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_MUL: begin
                    if (j_last) begin
                        j_reg <= '0;
                        if (i_last) begin
                            state_reg <= ST_DRAIN;
                        end else begin
                            i_reg <= i_reg + IDX_W'(1);
                        end
                    end else begin
                        j_reg <= j_reg + IDX_W'(1);
                    end
                end
                ST_DRAIN: begin
                    if (!mul_busy && !v3_reg) begin
                        state_reg   <= ST_SCAN;
                        sc_addr_reg <= ACC_AW'(ACC_DEPTH - 1);
                        sc_more_reg <= 1'b1;
                        ev_v_reg    <= 1'b0;
                        pend_v_reg  <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    if (!stall) begin
                        ev_v_reg    <= scan_issue;
                        ev_addr_reg <= sc_addr_reg;
                        // A nonzero entry waits until the next one shows whether it is last.
                        if (ev_nz) begin
                            pend_v_reg    <= 1'b1;
                            pend_coef_reg <= $signed(mem_rd);
                            pend_addr_reg <= ev_addr_reg;
                        end
                        if (scan_issue) begin
                            if (sc_addr_reg == '0) begin
                                sc_more_reg <= 1'b0;
                            end else begin
                                sc_addr_reg <= sc_addr_reg - ACC_AW'(1);
                            end
                        end
                    end
                    if (push_end) begin
                        state_reg   <= ST_IDLE;
                        pend_v_reg  <= 1'b0;
                        a_count_reg <= '0;
                        b_count_reg <= '0;
                        dropped_reg <= 1'b0;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (push_mid || push_end) begin
            m_ovf_reg <= dropped_reg;
            if (push_end && !pend_v_reg) begin
                m_coef_reg <= '0;
                m_exp_reg  <= '0;
                m_last_reg <= 1'b1;
                m_zero_reg <= 1'b1;
            end else begin
                m_coef_reg <= pend_coef_reg;
                m_exp_reg  <= REXP_W'(pend_addr_reg);
                m_last_reg <= push_end;
                m_zero_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_exp_reg, m_coef_reg};
    assign m_tuser  = {m_ovf_reg, m_zero_reg};
    assign m_tlast  = m_last_reg;

    // No result leaves while the accumulator is being cleared after reset.
    a_no_out_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !m_valid_reg)
        else $error("result presented during accumulator clear");

    // A regular result always carries a nonzero coefficient.
    a_nonzero_coef: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_zero_reg |-> m_coef_reg != '0)
        else $error("zero coefficient emitted as a term");

    // The zero-product item is always the final one.
    a_zero_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_zero_reg |-> m_last_reg)
        else $error("zero-product item without last");

    // Finishing a scan starts a new job with empty operands.
    a_job_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        push_end |=> a_count_reg == '0 && b_count_reg == '0 && !dropped_reg)
        else $error("operand counts not cleared after a job");

    // Stalled scan keeps the entry under evaluation.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |=> ev_v_reg && $stable(mem_rd))
        else $error("scan data lost while output stalled");

endmodule

// File: tb/sv/tb_sparse_polynomial_multiply.sv
`timescale 1ns / 1ps
// Self-checking testbench for sparse_polynomial_multiply: term loads and multiply requests
// in, product terms checked against an in-bench Q16.16 product accumulator. Needs spm_pkg.
module tb_sparse_polynomial_multiply;
    import spm_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic signed [31:0] COEF_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] COEF_MIN = 32'sh8000_0000;
    localparam int ACC_SLOTS = 2 * EXPMAX_DEFAULT + 1;
    localparam int RANDOM_REQUESTS = 300;
    localparam int HOLDOFF_CYCLES = 1000;
    localparam int STALL_LIMIT = 20000;
    localparam int REPORT_MAX = 10;

    typedef enum logic [1:0] {
        STEP_REQUEST,
        STEP_RX_HOLDOFF,
        STEP_DRAIN
    } step_kind_t;

    typedef struct {
        step_kind_t        step;
        logic [1:0]        kind;
        logic signed [31:0] coef;
        logic [7:0]        expo;
    } stim_step_t;

    typedef struct packed {
        logic signed [31:0] coef;
        logic [8:0]         expo;
        logic               last;
        logic               zero;
        logic               dropped;
    } product_term_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    sparse_polynomial_multiply DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Predicted state of the multiplier.
    logic signed [31:0] a_coef [0:TERMS_DEFAULT-1];
    logic [7:0]         a_expo [0:TERMS_DEFAULT-1];
    logic signed [31:0] b_coef [0:TERMS_DEFAULT-1];
    logic [7:0]         b_expo [0:TERMS_DEFAULT-1];
    int                 a_terms = 0;
    int                 b_terms = 0;
    logic signed [31:0] acc_by_expo [0:ACC_SLOTS-1] = '{default: '0};
    logic               terms_dropped = 1'b0;

    stim_step_t    pending_requests[$];
    product_term_t expected_terms[$];

    int   queued_count = 0;
    int   counted_requests = 0;
    int   accepted_count = 0;
    int   multiply_count = 0;
    int   terms_checked = 0;
    int   zero_products = 0;
    int   dropped_products = 0;
    int   fail_count = 0;
    int   idle_cycles = 0;
    int   cycle_count = 0;
    int   tx_gap = 0;
    int   rx_gap = 0;
    int   hold_left = 0;
    int   holdoff_requests = 0;
    int   holdoff_seen = 0;
    logic in_took = 1'b0;

    // A quarter of the run has no idling on either side.
    wire calm = (cycle_count[10:9] == 2'b11);

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int idle_len();
        int d;
        d = $urandom_range(99);
        if (calm || d < 65) return 0;
        if (d < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] clamp_q16(input longint v);
        if (v > longint'(COEF_MAX)) return COEF_MAX;
        if (v < longint'(COEF_MIN)) return COEF_MIN;
        return v[31:0];
    endfunction

    // Exact product, then floor shift by 16 and saturation.
    function automatic logic signed [31:0] q16_product(input logic signed [31:0] x,
                                                       input logic signed [31:0] y);
        longint wide;
        wide = longint'(x) * longint'(y);
        return clamp_q16(wide >>> 16);
    endfunction

    task automatic track_request(input logic [1:0] kind, input logic signed [31:0] coef,
                                 input logic [7:0] expo);
        product_term_t t;
        int            emitted;
        int            sum_expo;
        emitted = 0;
        if (kind == KIND_LOAD_A) begin
            if (a_terms < TERMS_DEFAULT) begin
                a_coef[a_terms] = coef;
                a_expo[a_terms] = expo;
                a_terms++;
            end else begin
                terms_dropped = 1'b1;
            end
        end else if (kind == KIND_LOAD_B) begin
            if (b_terms < TERMS_DEFAULT) begin
                b_coef[b_terms] = coef;
                b_expo[b_terms] = expo;
                b_terms++;
            end else begin
                terms_dropped = 1'b1;
            end
        end else if (kind == KIND_GO) begin
            multiply_count++;
            for (int i = 0; i < a_terms; i++) begin
                for (int j = 0; j < b_terms; j++) begin
                    sum_expo = a_expo[i] + b_expo[j];
                    acc_by_expo[sum_expo] = clamp_q16(longint'(acc_by_expo[sum_expo])
                        + longint'(q16_product(a_coef[i], b_coef[j])));
                end
            end
            for (int e = ACC_SLOTS - 1; e >= 0; e--) begin
                if (acc_by_expo[e] != 0) begin
                    if (emitted < 64) begin
                        t = '{coef: acc_by_expo[e], expo: e[8:0], last: 1'b0, zero: 1'b0,
                              dropped: terms_dropped};
                        expected_terms.push_back(t);
                        emitted++;
                    end
                    acc_by_expo[e] = '0;
                end
            end
            if (emitted == 0) begin
                t = '{coef: '0, expo: '0, last: 1'b1, zero: 1'b1, dropped: terms_dropped};
                expected_terms.push_back(t);
                zero_products++;
            end else begin
                expected_terms[expected_terms.size() - 1].last = 1'b1;
            end
            if (terms_dropped) dropped_products++;
            a_terms = 0;
            b_terms = 0;
            terms_dropped = 1'b0;
        end
    endtask

    // Request acceptance, result checking and the stall watchdog, all at the rising edge.
    always @(posedge aclk) begin
        product_term_t want;
        product_term_t got;
        logic          in_fire;
        logic          out_fire;
        in_fire = aresetn && s_tvalid && s_tready;
        out_fire = aresetn && m_tvalid && m_tready;
        in_took <= in_fire;
        cycle_count <= cycle_count + 1;
        if (in_fire) begin
            track_request(s_tuser, s_tdata[31:0], s_tdata[39:32]);
            accepted_count <= accepted_count + 1;
        end
        if (out_fire) begin
            got = '{coef: m_tdata[31:0], expo: m_tdata[40:32], last: m_tlast,
                    zero: m_tuser[0], dropped: m_tuser[1]};
            if (expected_terms.size() == 0) begin
                if (fail_count < REPORT_MAX)
                    $display("%0t: unexpected term coef %h expo %0d last %b zero %b ovf %b",
                             $realtime, got.coef, got.expo, got.last, got.zero, got.dropped);
                fail_count++;
            end else begin
                want = expected_terms.pop_front();
                terms_checked++;
                if (got !== want) begin
                    if (fail_count < REPORT_MAX) begin
                        $display("%0t: term mismatch: expected coef %h expo %0d last %b %s",
                                 $realtime, want.coef, want.expo, want.last,
                                 $sformatf("zero %b ovf %b", want.zero, want.dropped));
                        $display("%0t:                    got coef %h expo %0d last %b %s",
                                 $realtime, got.coef, got.expo, got.last,
                                 $sformatf("zero %b ovf %b", got.zero, got.dropped));
                    end
                    fail_count++;
                end
            end
        end
        if (aresetn) begin
            if (in_fire || out_fire) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no request or result moved for %0d cycles.", STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Request driver, fed from pending_requests.
    always @(negedge aclk) begin
        stim_step_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_took) begin
            // Request still waiting for s_tready.
        end else if (tx_gap > 0) begin
            s_tvalid <= 1'b0;
            tx_gap <= tx_gap - 1;
        end else if (pending_requests.size() == 0) begin
            s_tvalid <= 1'b0;
        end else if (pending_requests[0].step == STEP_RX_HOLDOFF) begin
            nxt = pending_requests.pop_front();
            holdoff_requests <= holdoff_requests + 1;
            s_tvalid <= 1'b0;
        end else if (pending_requests[0].step == STEP_DRAIN) begin
            s_tvalid <= 1'b0;
            if (expected_terms.size() == 0) nxt = pending_requests.pop_front();
        end else begin
            nxt = pending_requests.pop_front();
            s_tvalid <= 1'b1;
            s_tdata <= {nxt.expo, nxt.coef};
            s_tuser <= nxt.kind;
            tx_gap <= idle_len();
        end
    end

    // Result receiver with random stalls and the long hold-off.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (holdoff_requests != holdoff_seen) begin
            holdoff_seen <= holdoff_requests;
            hold_left <= HOLDOFF_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            rx_gap <= idle_len();
        end
    end

    task automatic push_request(input logic [1:0] kind, input logic signed [31:0] coef,
                                input logic [7:0] expo);
        stim_step_t s;
        s = '{step: STEP_REQUEST, kind: kind, coef: coef, expo: expo};
        pending_requests.push_back(s);
        queued_count++;
        if (kind != KIND_UNUSED) counted_requests++;
    endtask

    task automatic push_marker(input step_kind_t step);
        stim_step_t s;
        s = '{step: step, kind: KIND_UNUSED, coef: '0, expo: '0};
        pending_requests.push_back(s);
    endtask

    function automatic logic signed [31:0] rand_coef();
        case ($urandom_range(9))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return 32'sh0001_0000;
            3: return -32'sh0001_0000;
            4, 5: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_count();
        int d;
        d = $urandom_range(99);
        if (d < 5) return 0;
        if (d < 80) return $urandom_range(1, 4);
        if (d < 93) return $urandom_range(5, 8);
        return $urandom_range(9, 11);
    endfunction

    initial begin
        int na;
        int nb;
        int span;
        int k;
        int job_no;
        logic [7:0] e;

        // Directed part: empty operands, extremes, saturation both ways,
        // exact cancellation, dropped terms and an unused kind.
        push_request(KIND_GO, '0, '0);
        push_request(KIND_LOAD_A, COEF_MAX, 8'd255);
        push_request(KIND_LOAD_B, COEF_MAX, 8'd255);
        push_request(KIND_GO, '0, '0);
        push_request(KIND_LOAD_A, COEF_MIN, 8'd0);
        push_request(KIND_LOAD_A, COEF_MIN, 8'd0);
        push_request(KIND_LOAD_B, COEF_MAX, 8'd1);
        push_request(KIND_LOAD_B, COEF_MIN, 8'd0);
        push_request(KIND_GO, '0, '0);
        push_request(KIND_LOAD_A, 32'sh0001_0000, 8'd3);
        push_request(KIND_LOAD_A, -32'sh0001_0000, 8'd3);
        push_request(KIND_LOAD_B, 32'sh0001_0000, 8'd0);
        push_request(KIND_GO, '0, '0);
        for (int i = 0; i < TERMS_DEFAULT + 1; i++)
            push_request(KIND_LOAD_A, rand_coef(), 8'($urandom_range(255)));
        push_request(KIND_GO, '0, '0);
        push_request(KIND_UNUSED, $urandom, 8'($urandom_range(255)));

        // Random jobs: mostly loads followed by a multiply, some noise and overfull loads.
        job_no = 0;
        while (counted_requests < RANDOM_REQUESTS) begin
            job_no++;
            span = $urandom_range(1) ? 15 : 255;
            if (job_no == 9) push_marker(STEP_DRAIN);
            if (job_no == 4) begin
                // Full job while the receiver holds off, so results back up into the input.
                push_marker(STEP_RX_HOLDOFF);
                na = TERMS_DEFAULT;
                nb = TERMS_DEFAULT;
            end else if ($urandom_range(9) == 0) begin
                // Two A terms that cancel exactly at one exponent.
                k = $urandom_range(1, 200);
                e = 8'($urandom_range(span));
                push_request(KIND_LOAD_A, k * 65536, e);
                push_request(KIND_LOAD_A, -k * 65536, e);
                na = 0;
                nb = $urandom_range(1, 3);
            end else begin
                na = pick_count();
                nb = pick_count();
            end
            while (na > 0 || nb > 0) begin
                if (na > 0 && (nb == 0 || $urandom_range(1))) begin
                    push_request(KIND_LOAD_A, rand_coef(), 8'($urandom_range(span)));
                    na--;
                end else begin
                    push_request(KIND_LOAD_B, rand_coef(), 8'($urandom_range(span)));
                    nb--;
                end
                if ($urandom_range(29) == 0)
                    push_request(KIND_UNUSED, $urandom, 8'($urandom_range(255)));
            end
            push_request(KIND_GO, $urandom, 8'($urandom_range(255)));
            if ($urandom_range(19) == 0) push_marker(STEP_DRAIN);
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() != 0 || accepted_count != queued_count)
            @(negedge aclk);
        while (expected_terms.size() != 0)
            @(negedge aclk);
        repeat (ACC_SLOTS + 100) @(negedge aclk);

        if (expected_terms.size() != 0) begin
            $display("%0d expected terms never arrived.", expected_terms.size());
            fail_count += expected_terms.size();
        end
        $display("Ran %0d requests with %0d multiplies; %0d product terms checked.",
                 accepted_count, multiply_count, terms_checked);
        $display("Zero products: %0d, products with dropped terms: %0d, failures: %0d.",
                 zero_products, dropped_products, fail_count);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
